/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// Shared concurrent assertion forms. They compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression must hold at every rising clock edge outside reset
`define DT2D_CHECK(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// consequent must hold in the same cycle as the antecedent
`define DT2D_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define DT2D_CHECK(lbl, clk, rst_n, expr, msg)
`define DT2D_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/dt2d_pkg.sv */
// ----------------------------------------------------------------------------
// dt2d_pkg
// Types and constants shared by the drift time to distance converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dt2d_pkg;

	// input beat: one chamber hit
	typedef struct packed {
		logic signed [15:0] drift_time;
		logic signed [15:0] track_slope;
	} hit_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ZERO_SLOPE = 2'd1,
		ST_NEG_TIME   = 2'd2,
		ST_SATURATED  = 2'd3
	} status_t;

	// output beat: converted distance
	typedef struct packed {
		logic signed [19:0] distance;
		status_t            status;
	} dist_t;

	// classified hit waiting in the queue
	typedef struct packed {
		logic signed [15:0] slope;
		logic [30:0]        p;
		logic               zero;
		logic               neg;
	} qitem_t;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_VELOCITY = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_A1_COEFFS      = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_A2_COEFFS      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_CENTER   = 8'd3;

	localparam logic [15:0] VELOCITY_RST = 16'd51200;
	localparam logic [63:0] A1_RST       = 64'd16000;
	localparam logic [63:0] A2_RST       = 64'd0;
	localparam logic [15:0] CENTER_RST   = 16'd5734;

	localparam int POLY_TERMS_DEF = 4;
	localparam int QUEUE_DEPTH    = 4;

	// arithmetic limits
	localparam logic signed [32:0] ACC_LIM = 33'sd2147483647;
	localparam logic signed [32:0] ACC_NEG = -33'sd2147483647;
	localparam logic signed [19:0] DIST_MAX = 20'sd524287;
	localparam logic signed [19:0] DIST_MIN = -20'sd524288;

	// reciprocal divider: round(2^24 / |slope|)
	localparam int REC_NUM_W = 25;
	localparam int REC_DEN_W = 16;
	localparam int REC_Q_W   = 25;

	// ratio divider: round(p * a2 / a1), quotient bounded by 1024 * |a2|
	localparam int RAT_NUM_W = 63;
	localparam int RAT_DEN_W = 31;
	localparam int RAT_Q_W   = 42;

endpackage

`default_nettype wire

/* rtl/core/dt2d_front.sv */
// ----------------------------------------------------------------------------
// dt2d_front
// Accepts hits, forms the raw distance and flags zero slope and negative time.
// ----------------------------------------------------------------------------
`default_nettype none

module dt2d_front (
	input  wire logic             hit_valid,
	output logic                  hit_stall,
	input  wire dt2d_pkg::hit_t   hit,
	input  wire logic [15:0]      drift_velocity,
	input  wire logic             q_full,
	output logic                  push,
	output dt2d_pkg::qitem_t      push_data
);

	logic signed [32:0] p_raw;

	// raw distance in 2^-13 um
	assign p_raw = $signed({17'b0, drift_velocity}) * $signed({{17{hit.drift_time[15]}},
		hit.drift_time});

	// classify and hand to the queue
	always_comb begin
		push_data.slope = hit.track_slope;
		push_data.p     = p_raw[30:0];
		push_data.zero  = (hit.track_slope == 16'sd0);
		push_data.neg   = p_raw[32];
	end

	assign hit_stall = q_full;
	assign push      = hit_valid && !q_full;

endmodule

`default_nettype wire

/* rtl/core/dt2d_fifo.sv */
// ----------------------------------------------------------------------------
// dt2d_fifo
// Short queue between the front and the back so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dt2d_fifo #(
	parameter int DEPTH = dt2d_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire dt2d_pkg::qitem_t   wdata,
	output logic                    full,
	input  wire logic               pop,
	output dt2d_pkg::qitem_t        rdata,
	output logic                    nonempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	dt2d_pkg::qitem_t  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rd_ptr_q];

	`DT2D_CHECK(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "queue count overflow")
	`DT2D_IMPLY(a_no_push_full, clk, arst_n, full, !push, "push into full queue")
	`DT2D_IMPLY(a_no_pop_empty, clk, arst_n, !nonempty, !pop, "pop from empty queue")

endmodule

`default_nettype wire

/* rtl/core/dt2d_div.sv */
// ----------------------------------------------------------------------------
// dt2d_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module dt2d_div #(
	parameter int NUM_W  = dt2d_pkg::REC_NUM_W,
	parameter int DEN_W  = dt2d_pkg::REC_DEN_W,
	parameter int Q_W    = dt2d_pkg::REC_Q_W,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	output logic [Q_W-1:0]         quo,
	output logic [SIDE_W-1:0]      side_out
);

	localparam int TOP_W = NUM_W - Q_W;

	logic              vld_s  [Q_W];
	logic [DEN_W-1:0]  rem_s  [Q_W];
	logic [Q_W-1:0]    quo_s  [Q_W];
	logic [NUM_W-1:0]  num_s  [Q_W];
	logic [DEN_W-1:0]  den_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];
	logic [DEN_W-1:0]  rem_init;

	// bits above the quotient range seed the remainder
	if (TOP_W > 0) begin : g_top
		assign rem_init = DEN_W'(num[NUM_W-1:Q_W]);
	end else begin : g_notop
		assign rem_init = '0;
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic              vld_in;
		logic [DEN_W-1:0]  rem_in;
		logic [Q_W-1:0]    quo_in;
		logic [NUM_W-1:0]  num_in;
		logic [DEN_W-1:0]  den_in;
		logic [SIDE_W-1:0] side_k;
		logic [DEN_W:0]    trial;
		logic              ge;
		logic [Q_W:0]      quo_nx;

		if (k == 0) begin : g_first
			assign vld_in = in_valid;
			assign rem_in = rem_init;
			assign quo_in = '0;
			assign num_in = num;
			assign den_in = den;
			assign side_k = side_in;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign num_in = num_s[k-1];
			assign den_in = den_s[k-1];
			assign side_k = side_s[k-1];
		end

		// trial subtract of the next numerator bit
		assign trial  = {rem_in, num_in[Q_W-1-k]};
		assign ge     = (trial >= {1'b0, den_in});
		assign quo_nx = {quo_in, ge};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
				quo_s[k]  <= quo_nx[Q_W-1:0];
				num_s[k]  <= num_in;
				den_s[k]  <= den_in;
				side_s[k] <= side_k;
			end
		end
	end

	assign out_valid = vld_s[Q_W-1];
	assign quo       = quo_s[Q_W-1];
	assign side_out  = side_s[Q_W-1];

endmodule

`default_nettype wire

/* rtl/core/dt2d_back.sv */
// ----------------------------------------------------------------------------
// dt2d_back
// Reciprocal, Horner correction polynomials, ratio scaling and output rounding.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dt2d_back #(
	parameter int POLY_TERMS = dt2d_pkg::POLY_TERMS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dt2d_pkg::qitem_t  head,
	input  wire logic              head_vld,
	output logic                   pop,
	input  wire logic [63:0]       a1_coeffs,
	input  wire logic [63:0]       a2_coeffs,
	input  wire logic [15:0]       slope_center,
	output logic                   dist_valid,
	input  wire logic              dist_stall,
	output dt2d_pkg::dist_t        dist_data
);

	localparam int H    = POLY_TERMS - 1;
	localparam int HM_N = (H > 0) ? H : 1;

	typedef struct packed {
		logic        zero;
		logic        neg;
		logic [30:0] p;
	} tag_t;

	typedef struct packed {
		logic sgn;
		tag_t tag;
	} d1side_t;

	typedef struct packed {
		tag_t               tag;
		logic signed [25:0] x;
		logic signed [31:0] acc1;
		logic signed [31:0] acc2;
	} hsum_t;

	typedef struct packed {
		tag_t               tag;
		logic signed [25:0] x;
		logic signed [58:0] pr1;
		logic signed [58:0] pr2;
	} hmul_t;

	typedef struct packed {
		tag_t               tag;
		logic signed [31:0] a1;
		logic signed [31:0] a2;
	} fin_t;

	typedef struct packed {
		tag_t               tag;
		logic signed [31:0] a1;
		logic signed [31:0] a2;
		logic signed [62:0] prod;
	} mul_t;

	typedef struct packed {
		logic               sgn;
		logic               below;
		logic signed [42:0] d_else;
		tag_t               tag;
	} d2side_t;

	typedef struct packed {
		d2side_t                 side;
		logic [62:0]             num;
		logic [30:0]             den;
	} dvd_t;

	typedef struct packed {
		tag_t               tag;
		logic signed [42:0] d;
	} sum_t;

	// signed coefficient lane
	function automatic logic signed [15:0] lane(input logic [63:0] w, input int i);
		return w[16*i +: 16];
	endfunction

	// round a Horner product by 4096, halves away from zero, then clamp
	function automatic logic signed [31:0] rnd_acc(input logic signed [58:0] v);
		logic [58:0] m;
		logic [59:0] rs;
		logic [30:0] mag;
		m  = v[58] ? 59'(-v) : 59'(v);
		rs = ({1'b0, m} + 60'd2048) >> 12;
		mag = (rs[59:31] != '0) ? 31'h7fffffff : rs[30:0];
		return v[58] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	// clamp a grown accumulator back into range
	function automatic logic signed [31:0] clamp_acc(input logic signed [32:0] v);
		logic signed [32:0] c;
		if (v > dt2d_pkg::ACC_LIM) begin
			c = dt2d_pkg::ACC_LIM;
		end else if (v < dt2d_pkg::ACC_NEG) begin
			c = dt2d_pkg::ACC_NEG;
		end else begin
			c = v;
		end
		return c[31:0];
	endfunction

	// final rounding to 1/16 um, saturation and status
	function automatic dt2d_pkg::dist_t to_dist(input logic signed [42:0] d, input tag_t t);
		logic [42:0] m;
		logic [43:0] r;
		logic [19:0] rl;
		dt2d_pkg::dist_t o;
		m  = d[42] ? 43'(-d) : 43'(d);
		r  = ({1'b0, m} + 44'd256) >> 9;
		rl = r[19:0];
		if (t.zero) begin
			o.distance = '0;
			o.status   = dt2d_pkg::ST_ZERO_SLOPE;
		end else if (t.neg) begin
			o.distance = '0;
			o.status   = dt2d_pkg::ST_NEG_TIME;
		end else if (!d[42] && r > 44'd524287) begin
			o.distance = dt2d_pkg::DIST_MAX;
			o.status   = dt2d_pkg::ST_SATURATED;
		end else if (d[42] && r > 44'd524288) begin
			o.distance = dt2d_pkg::DIST_MIN;
			o.status   = dt2d_pkg::ST_SATURATED;
		end else begin
			o.distance = d[42] ? -rl : rl;
			o.status   = dt2d_pkg::ST_OK;
		end
		return o;
	endfunction

	logic             en;
	logic [15:0]      mag;
	d1side_t          d1_side_in;
	logic             d1_vld;
	logic [24:0]      d1_quo;
	logic [$bits(d1side_t)-1:0] d1_side_raw;
	d1side_t          d1_side;
	logic signed [25:0] x_new;

	hsum_t            hsum_s     [H+1];
	logic             hsum_vld_s [H+1];
	hmul_t            hmul_s     [HM_N];
	logic             hmul_vld_s [HM_N];

	fin_t             fin_s4;
	logic             fin_vld_s4;
	mul_t             mul_s5;
	logic             mul_vld_s5;
	dvd_t             dvd_s6;
	logic             dvd_vld_s6;

	logic             d2_vld;
	logic [41:0]      d2_quo;
	logic [$bits(d2side_t)-1:0] d2_side_raw;
	d2side_t          d2_side;

	sum_t             sum_s7;
	logic             sum_vld_s7;
	dt2d_pkg::dist_t  out_q;
	logic             out_vld_q;

	// the whole back pipeline advances while the output slot can take a beat
	assign en  = !out_vld_q || !dist_stall;
	assign pop = head_vld && en;

	// reciprocal of the slope magnitude
	assign mag = head.slope[15] ? 16'(-head.slope) : 16'(head.slope);
	always_comb begin
		d1_side_in.sgn      = head.slope[15];
		d1_side_in.tag.zero = head.zero;
		d1_side_in.tag.neg  = head.neg;
		d1_side_in.tag.p    = head.p;
	end

	dt2d_div #(
		.NUM_W (dt2d_pkg::REC_NUM_W),
		.DEN_W (dt2d_pkg::REC_DEN_W),
		.Q_W   (dt2d_pkg::REC_Q_W),
		.SIDE_W($bits(d1side_t))
	) u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (head_vld),
		.num      (25'h1000000 + 25'(mag[15:1])),
		.den      (mag),
		.side_in  (d1_side_in),
		.out_valid(d1_vld),
		.quo      (d1_quo),
		.side_out (d1_side_raw)
	);

	assign d1_side = d1_side_raw;

	// x = +-1/slope - slope_center
	always_comb begin
		logic signed [25:0] qs;
		qs    = $signed({1'b0, d1_quo});
		x_new = (d1_side.sgn ? -qs : qs) - $signed({10'b0, slope_center});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsum_vld_s[0] <= 1'b0;
		end else if (en) begin
			hsum_vld_s[0] <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hsum_s[0].tag  <= d1_side.tag;
			hsum_s[0].x    <= x_new;
			hsum_s[0].acc1 <= '0;
			hsum_s[0].acc2 <= '0;
		end
	end

	// Horner steps, highest power first: multiply stage then round stage
	for (genvar k = 0; k < H; k++) begin : g_horner
		localparam int LI = POLY_TERMS - 1 - k;
		logic signed [32:0] s1;
		logic signed [32:0] s2;
		logic signed [15:0] c1;
		logic signed [15:0] c2;

		assign c1 = lane(a1_coeffs, LI);
		assign c2 = lane(a2_coeffs, LI);
		assign s1 = {hsum_s[k].acc1[31], hsum_s[k].acc1} + {{17{c1[15]}}, c1};
		assign s2 = {hsum_s[k].acc2[31], hsum_s[k].acc2} + {{17{c2[15]}}, c2};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hmul_vld_s[k]   <= 1'b0;
				hsum_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				hmul_vld_s[k]   <= hsum_vld_s[k];
				hsum_vld_s[k+1] <= hmul_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hmul_s[k].tag    <= hsum_s[k].tag;
				hmul_s[k].x      <= hsum_s[k].x;
				hmul_s[k].pr1    <= s1 * hsum_s[k].x;
				hmul_s[k].pr2    <= s2 * hsum_s[k].x;
				hsum_s[k+1].tag  <= hmul_s[k].tag;
				hsum_s[k+1].x    <= hmul_s[k].x;
				hsum_s[k+1].acc1 <= rnd_acc(hmul_s[k].pr1);
				hsum_s[k+1].acc2 <= rnd_acc(hmul_s[k].pr2);
			end
		end
	end

	if (H == 0) begin : g_nohorner
		assign hmul_vld_s[0] = 1'b0;
		assign hmul_s[0]     = '0;
	end

	// constant term, then p * a2, then divider operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_s4 <= 1'b0;
			mul_vld_s5 <= 1'b0;
			dvd_vld_s6 <= 1'b0;
		end else if (en) begin
			fin_vld_s4 <= hsum_vld_s[H];
			mul_vld_s5 <= fin_vld_s4;
			dvd_vld_s6 <= mul_vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [15:0] c1;
		logic signed [15:0] c2;
		logic [62:0]        mp;
		c1 = lane(a1_coeffs, 0);
		c2 = lane(a2_coeffs, 0);
		mp = mul_s5.prod[62] ? 63'(-mul_s5.prod) : 63'(mul_s5.prod);
		if (en) begin
			fin_s4.tag <= hsum_s[H].tag;
			fin_s4.a1  <= clamp_acc({hsum_s[H].acc1[31], hsum_s[H].acc1} + {{17{c1[15]}}, c1});
			fin_s4.a2  <= clamp_acc({hsum_s[H].acc2[31], hsum_s[H].acc2} + {{17{c2[15]}}, c2});

			mul_s5.tag  <= fin_s4.tag;
			mul_s5.a1   <= fin_s4.a1;
			mul_s5.a2   <= fin_s4.a2;
			mul_s5.prod <= $signed({1'b0, fin_s4.tag.p}) * fin_s4.a2;

			dvd_s6.side.sgn    <= mul_s5.prod[62];
			dvd_s6.side.below  <= $signed({11'b0, mul_s5.tag.p}) < $signed({mul_s5.a1, 10'b0});
			dvd_s6.side.d_else <= $signed({12'b0, mul_s5.tag.p})
				+ $signed({mul_s5.a2[31], mul_s5.a2, 10'b0});
			dvd_s6.side.tag    <= mul_s5.tag;
			dvd_s6.num         <= mp + 63'(mul_s5.a1[30:1]);
			dvd_s6.den         <= mul_s5.a1[30:0];
		end
	end

	// ratio p * a2 / a1 for hits with p below 1024 * a1
	dt2d_div #(
		.NUM_W (dt2d_pkg::RAT_NUM_W),
		.DEN_W (dt2d_pkg::RAT_DEN_W),
		.Q_W   (dt2d_pkg::RAT_Q_W),
		.SIDE_W($bits(d2side_t))
	) u_ratio (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (dvd_vld_s6),
		.num      (dvd_s6.num),
		.den      (dvd_s6.den),
		.side_in  (dvd_s6.side),
		.out_valid(d2_vld),
		.quo      (d2_quo),
		.side_out (d2_side_raw)
	);

	assign d2_side = d2_side_raw;

	// pick scaled or offset distance, then round into the output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_vld_s7 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else if (en) begin
			sum_vld_s7 <= d2_vld;
			out_vld_q  <= sum_vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [42:0] qs;
		qs = $signed({1'b0, d2_quo});
		if (en) begin
			sum_s7.tag <= d2_side.tag;
			sum_s7.d   <= d2_side.below
				? $signed({12'b0, d2_side.tag.p}) + (d2_side.sgn ? -qs : qs)
				: d2_side.d_else;
			out_q      <= to_dist(sum_s7.d, sum_s7.tag);
		end
	end

	assign dist_valid = out_vld_q;
	assign dist_data  = out_q;

	`DT2D_IMPLY(a_flag_zero_dist, clk, arst_n, out_vld_q && (out_q.status == dt2d_pkg::ST_ZERO_SLOPE || out_q.status == dt2d_pkg::ST_NEG_TIME), out_q.distance == '0, "flagged beat with nonzero distance")
	`DT2D_IMPLY(a_sat_bound, clk, arst_n, out_vld_q && out_q.status == dt2d_pkg::ST_SATURATED, out_q.distance == dt2d_pkg::DIST_MAX || out_q.distance == dt2d_pkg::DIST_MIN, "saturated beat not at a bound")
	`DT2D_IMPLY(a_pop_moves, clk, arst_n, pop, en, "queue popped while pipeline held")

endmodule

`default_nettype wire

/* rtl/core/drift_time_to_distance.sv */
// ----------------------------------------------------------------------------
// drift_time_to_distance
// Converts a chamber drift time and track slope into a drift distance.
// ----------------------------------------------------------------------------
// One hit is taken every cycle and one distance beat leaves every cycle when
// the output is not stalled. The latency is set by the 25-stage reciprocal
// divider, a multiply stage and a round stage for each of the POLY_TERMS - 1
// Horner steps (three at the default of four terms), and the 42-stage ratio
// divider. A four-entry queue sits between the hit front end and the
// arithmetic pipeline, so hits are still taken after the output stalls until
// the queue fills. Write configuration only while no hit is in flight.
`default_nettype none

module drift_time_to_distance #(
	parameter int POLY_TERMS = dt2d_pkg::POLY_TERMS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              hit_valid,
	output logic                                   hit_stall,
	input  wire dt2d_pkg::hit_t                    hit,
	output logic                                   dist_valid,
	input  wire logic                              dist_stall,
	output dt2d_pkg::dist_t                        dist_data,
	input  wire logic                              cfg_wen,
	input  wire logic [dt2d_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dt2d_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	logic [15:0]      velocity_q;
	logic [63:0]      a1_q;
	logic [63:0]      a2_q;
	logic [15:0]      center_q;

	logic             q_full;
	logic             push;
	dt2d_pkg::qitem_t push_data;
	logic             pop;
	dt2d_pkg::qitem_t head;
	logic             head_vld;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			velocity_q <= dt2d_pkg::VELOCITY_RST;
			a1_q       <= dt2d_pkg::A1_RST;
			a2_q       <= dt2d_pkg::A2_RST;
			center_q   <= dt2d_pkg::CENTER_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				dt2d_pkg::CFG_DRIFT_VELOCITY: velocity_q <= cfg_wdata[15:0];
				dt2d_pkg::CFG_A1_COEFFS:      a1_q       <= cfg_wdata;
				dt2d_pkg::CFG_A2_COEFFS:      a2_q       <= cfg_wdata;
				dt2d_pkg::CFG_SLOPE_CENTER:   center_q   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	dt2d_front u_front (
		.hit_valid     (hit_valid),
		.hit_stall     (hit_stall),
		.hit           (hit),
		.drift_velocity(velocity_q),
		.q_full        (q_full),
		.push          (push),
		.push_data     (push_data)
	);

	dt2d_fifo #(
		.DEPTH(dt2d_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wdata   (push_data),
		.full    (q_full),
		.pop     (pop),
		.rdata   (head),
		.nonempty(head_vld)
	);

	dt2d_back #(
		.POLY_TERMS(POLY_TERMS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_vld    (head_vld),
		.pop         (pop),
		.a1_coeffs   (a1_q),
		.a2_coeffs   (a2_q),
		.slope_center(center_q),
		.dist_valid  (dist_valid),
		.dist_stall  (dist_stall),
		.dist_data   (dist_data)
	);

endmodule

`default_nettype wire
